// ===== hdl/block_range_minimum_query_defines.svh =====
// Assertion macros for the block range-minimum-query unit.
`ifndef BLOCK_RANGE_MINIMUM_QUERY_DEFINES_SVH
`define BLOCK_RANGE_MINIMUM_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRMQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brmq_pkg.sv =====
// Shared constants and codes of the block range-minimum-query unit.
`default_nettype none

package brmq_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_BLK_LEN      = 8;
    localparam int DEF_VALUE_WIDTH  = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_BUILD = 2'd1;
    localparam op_t OP_QUERY = 2'd2;

    typedef logic [1:0] stat_t;
    localparam stat_t ST_ANSWER = 2'd0;
    localparam stat_t ST_DONE   = 2'd1;
    localparam stat_t ST_ERROR  = 2'd2;

    // Regions of the element memory
    typedef logic [1:0] region_t;
    localparam region_t RG_VAL = 2'd0;
    localparam region_t RG_PRE = 2'd1;
    localparam region_t RG_SUF = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/brmq_blkdiv.sv =====
// Registered block-number computation for two element indexes (divide by constant).
`default_nettype none

module brmq_blkdiv #(
    parameter int IDX_W   = 10,
    parameter int BLK_W   = 7,
    parameter int BLK_LEN = 8
) (
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] idx_a,
    input  wire logic [IDX_W-1:0] idx_b,
    output logic      [BLK_W-1:0] blk_a,
    output logic      [BLK_W-1:0] blk_b
);

    // floor(x / d) = (x * ceil(2^(N+l) / d)) >> (N+l), l = ceil(log2 d), exact for x < 2^N
    localparam int POS_W = $clog2(BLK_LEN);
    localparam int RSH   = IDX_W + POS_W;
    localparam int RC_W  = IDX_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << RSH) + 64'(BLK_LEN) - 64'd1) / 64'(BLK_LEN);
    localparam int PR_W  = IDX_W + RC_W;

    logic [RC_W-1:0] recip;
    logic [PR_W-1:0] prod_a;
    logic [PR_W-1:0] prod_b;

    assign recip  = RC_W'(RECIP);
    assign prod_a = PR_W'(idx_a) * PR_W'(recip);
    assign prod_b = PR_W'(idx_b) * PR_W'(recip);

    always_ff @(posedge clk)
    begin
        blk_a <= prod_a[RSH +: BLK_W];
        blk_b <= prod_b[RSH +: BLK_W];
    end

endmodule

`default_nettype wire

// ===== hdl/block_range_minimum_query.sv =====
// Block range-minimum-query unit, top level. Holds an array of signed words in
// an element memory. A write word stores one value. A build word walks the
// first element_count entries: a forward pass fills per-block prefix minima
// and the block minima, a backward pass fills suffix minima, and a sweep fills
// a sparse table over the block minima; each entry takes a read step and a
// write step on the memory's single write port, and each sparse row is closed
// by a step of its own. A query word returns the leftmost index of the minimum
// over left_index..right_index and its value: a range across blocks goes through
// a block-number multiply, one parallel read of suffix, prefix and two sparse
// entries, three compare steps, and the output load; a range inside one block
// is scanned one element at a time, a read step and a compare step per element.
// Queries before a build, after any write or count change, with left_index >
// right_index, or right_index >= element_count return the error status. The
// unit takes one word at a time; in_stall is high while a build or a query is
// in progress or its result waits for the output register. element_count is
// written on cfg_wr_en; 0 is taken as 1 and values above the element capacity
// are clamped. Write configuration only while the unit is idle.
`default_nettype none

module block_range_minimum_query #(
    parameter int MAX_ELEMENTS = brmq_pkg::DEF_MAX_ELEMENTS,
    parameter int BLK_LEN      = brmq_pkg::DEF_BLK_LEN,
    parameter int VALUE_WIDTH  = brmq_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]       cfg_wr_data,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire brmq_pkg::op_t                           opcode,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]         left_index,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]         right_index,
    input  wire logic signed [VALUE_WIDTH-1:0]           element_value,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output brmq_pkg::stat_t                              status,
    output logic [$clog2(MAX_ELEMENTS)-1:0]              min_index,
    output logic signed [VALUE_WIDTH-1:0]                min_value
);

    import brmq_pkg::*;

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W   = $clog2(BLK_LEN);
    localparam int BLK_CNT = (MAX_ELEMENTS + BLK_LEN - 1) / BLK_LEN;
    localparam int BLK_W   = (BLK_CNT > 1) ? $clog2(BLK_CNT) : 1;
    localparam int BC_W    = $clog2(BLK_CNT + 1);
    localparam int SP_W    = BC_W + 1;
    localparam int LEV_N   = $clog2(BLK_CNT) + 1;
    localparam int LEV_W   = (LEV_N > 1) ? $clog2(LEV_N) : 1;
    localparam int E_W     = IDX_W + VALUE_WIDTH;
    localparam int EA_W    = IDX_W + 2;
    localparam int SA_W    = LEV_W + BLK_W;
    localparam int EM_DEPTH = 1 << EA_W;
    localparam int SM_DEPTH = 1 << SA_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EMIT   = 4'd1;
    localparam logic [3:0] S_FWD_RD = 4'd2;
    localparam logic [3:0] S_FWD_WR = 4'd3;
    localparam logic [3:0] S_BWD_RD = 4'd4;
    localparam logic [3:0] S_BWD_WR = 4'd5;
    localparam logic [3:0] S_SP_RD  = 4'd6;
    localparam logic [3:0] S_SP_WR  = 4'd7;
    localparam logic [3:0] S_Q_DIV  = 4'd8;
    localparam logic [3:0] S_Q_PLAN = 4'd9;
    localparam logic [3:0] S_Q_CMP1 = 4'd10;
    localparam logic [3:0] S_Q_CMP2 = 4'd11;
    localparam logic [3:0] S_Q_CMP3 = 4'd12;
    localparam logic [3:0] S_SC_RD  = 4'd13;
    localparam logic [3:0] S_SC_CMP = 4'd14;

    // An entry is {index, value}; order by signed value, ties kept by the caller.
    function automatic logic less_e(input logic [E_W-1:0] a, input logic [E_W-1:0] b);
        return $signed(a[VALUE_WIDTH-1:0]) < $signed(b[VALUE_WIDTH-1:0]);
    endfunction

    function automatic logic [LEV_W-1:0] flog2(input logic [BLK_W-1:0] v);
        logic [LEV_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLK_W; n++)
        begin
            if (v[n])
                r = LEV_W'(n);
        end
        return r;
    endfunction

    // control state
    logic [3:0]       state_reg, state_next;
    logic             tv_reg, tv_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // datapath state
    logic [IDX_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [E_W-1:0]   run_reg, run_next;
    logic [E_W-1:0]   tmp_reg, tmp_next;
    logic [E_W-1:0]   p_reg, p_next;
    logic             fresh_reg, fresh_next;
    logic [BC_W-1:0]  bc_reg, bc_next;
    logic [LEV_W-1:0] lev_reg, lev_next;
    logic [BLK_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] qi_reg, qi_next;
    logic [IDX_W-1:0] qj_reg, qj_next;
    logic             use_reg, use_next;
    stat_t            res_status_reg, res_status_next;
    logic [E_W-1:0]   res_e_reg, res_e_next;
    stat_t            out_status_reg, out_status_next;
    logic [E_W-1:0]   out_e_reg, out_e_next;

    // element memory: values, prefix and suffix minima, one region each
    logic [E_W-1:0]  emem [0:EM_DEPTH-1];
    logic            e_we;
    logic [EA_W-1:0] e_waddr, ea_addr, eb_addr;
    logic [E_W-1:0]  e_wdata, ea_q_reg, eb_q_reg;

    // sparse table over block minima, row = level
    logic [E_W-1:0]  smem [0:SM_DEPTH-1];
    logic            s_we;
    logic [SA_W-1:0] s_waddr, sa_addr, sb_addr;
    logic [E_W-1:0]  s_wdata, sa_q_reg, sb_q_reg;

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[e_waddr] <= e_wdata;
        ea_q_reg <= emem[ea_addr];
        eb_q_reg <= emem[eb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_waddr] <= s_wdata;
        sa_q_reg <= smem[sa_addr];
        sb_q_reg <= smem[sb_addr];
    end

    // block numbers of the query ends
    logic [BLK_W-1:0] bi, bj;

    brmq_blkdiv #(
        .IDX_W   (IDX_W),
        .BLK_W   (BLK_W),
        .BLK_LEN (BLK_LEN)
    ) u_blkdiv (
        .clk   (clk),
        .idx_a (qi_reg),
        .idx_b (qj_reg),
        .blk_a (bi),
        .blk_b (bj)
    );

    // helpers
    logic [E_W-1:0]   cur_e;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic             blk_end;
    logic [E_W-1:0]   run_fwd, run_bwd, run_scan, t_sel;
    logic [SP_W-1:0]  span;
    logic             lvl_over;
    logic [LEV_W-1:0] lev_m1;
    logic [BLK_W-1:0] half;
    logic [BLK_W-1:0] bi_p1, q_len, q_pow;
    logic [LEV_W-1:0] q_lev;
    logic             q_err;
    logic [CNT_W-1:0] cfg_clamped;

    always_comb
    begin
        cur_e    = {k_reg, ea_q_reg[VALUE_WIDTH-1:0]};
        cnt_m1   = cnt_reg - CNT_W'(1);
        last_idx = cnt_m1[IDX_W-1:0];
        blk_end  = (pos_reg == POS_W'(BLK_LEN - 1)) || (k_reg == last_idx);
        run_fwd  = ((pos_reg == '0) || less_e(cur_e, run_reg)) ? cur_e : run_reg;
        // suffix: the lower index wins ties
        run_bwd  = (fresh_reg || !less_e(run_reg, cur_e)) ? cur_e : run_reg;
        run_scan = ((k_reg == qi_reg) || less_e(cur_e, run_reg)) ? cur_e : run_reg;
        t_sel    = less_e(sb_q_reg, sa_q_reg) ? sb_q_reg : sa_q_reg;
        span     = SP_W'(1) << lev_reg;
        lvl_over = (SP_W'(b_reg) + span) > SP_W'(bc_reg);
        lev_m1   = lev_reg - LEV_W'(1);
        half     = BLK_W'(1) << lev_m1;
        bi_p1    = bi + BLK_W'(1);
        q_len    = bj - bi_p1;
        q_lev    = flog2(q_len);
        q_pow    = BLK_W'(1) << q_lev;
        q_err    = !tv_reg || (left_index > right_index)
                   || (CNT_W'(right_index) >= cnt_reg);
        if (cfg_wr_data == '0)
            cfg_clamped = CNT_W'(1);
        else if (cfg_wr_data > CNT_W'(MAX_ELEMENTS))
            cfg_clamped = CNT_W'(MAX_ELEMENTS);
        else
            cfg_clamped = cfg_wr_data;
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        tv_next         = tv_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        blk_next        = blk_reg;
        run_next        = run_reg;
        tmp_next        = tmp_reg;
        p_next          = p_reg;
        fresh_next      = fresh_reg;
        bc_next         = bc_reg;
        lev_next        = lev_reg;
        b_next          = b_reg;
        qi_next         = qi_reg;
        qj_next         = qj_reg;
        use_next        = use_reg;
        res_status_next = res_status_reg;
        res_e_next      = res_e_reg;
        out_status_next = out_status_reg;
        out_e_next      = out_e_reg;
        e_we    = 1'b0;
        e_waddr = '0;
        e_wdata = '0;
        ea_addr = '0;
        eb_addr = '0;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        sa_addr = '0;
        sb_addr = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_wr_en)
        begin
            cnt_next = cfg_clamped;
            tv_next  = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_WRITE:
                        begin
                            if (CNT_W'(left_index) < CNT_W'(MAX_ELEMENTS))
                            begin
                                e_we    = 1'b1;
                                e_waddr = {RG_VAL, left_index};
                                e_wdata = {{IDX_W{1'b0}}, element_value};
                                tv_next = 1'b0;
                            end
                        end
                        OP_BUILD:
                        begin
                            k_next     = '0;
                            pos_next   = '0;
                            blk_next   = '0;
                            state_next = S_FWD_RD;
                        end
                        OP_QUERY:
                        begin
                            if (q_err)
                            begin
                                res_status_next = ST_ERROR;
                                res_e_next      = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                qi_next    = left_index;
                                qj_next    = right_index;
                                state_next = S_Q_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_e_next      = res_e_reg;
                    state_next      = S_IDLE;
                end
            end

            // forward pass: prefix minima and block minima
            S_FWD_RD:
            begin
                ea_addr    = {RG_VAL, k_reg};
                state_next = S_FWD_WR;
            end

            S_FWD_WR:
            begin
                e_we     = 1'b1;
                e_waddr  = {RG_PRE, k_reg};
                e_wdata  = run_fwd;
                run_next = run_fwd;
                if (blk_end)
                begin
                    s_we    = 1'b1;
                    s_waddr = {LEV_W'(0), blk_reg};
                    s_wdata = run_fwd;
                end
                if (k_reg == last_idx)
                begin
                    // pos_reg already holds the position of the last element
                    bc_next    = BC_W'(blk_reg) + BC_W'(1);
                    fresh_next = 1'b1;
                    state_next = S_BWD_RD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    pos_next   = blk_end ? '0 : pos_reg + POS_W'(1);
                    blk_next   = blk_end ? blk_reg + BLK_W'(1) : blk_reg;
                    state_next = S_FWD_RD;
                end
            end

            // backward pass: suffix minima
            S_BWD_RD:
            begin
                ea_addr    = {RG_VAL, k_reg};
                state_next = S_BWD_WR;
            end

            S_BWD_WR:
            begin
                e_we       = 1'b1;
                e_waddr    = {RG_SUF, k_reg};
                e_wdata    = run_bwd;
                run_next   = run_bwd;
                fresh_next = (pos_reg == '0);
                pos_next   = (pos_reg == '0) ? POS_W'(BLK_LEN - 1) : pos_reg - POS_W'(1);
                if (k_reg == '0)
                begin
                    lev_next   = LEV_W'(1);
                    b_next     = '0;
                    state_next = S_SP_RD;
                end
                else
                begin
                    k_next     = k_reg - IDX_W'(1);
                    state_next = S_BWD_RD;
                end
            end

            // sparse table, one level per row
            S_SP_RD:
            begin
                if (lvl_over)
                begin
                    if ((b_reg == '0) || (lev_reg == LEV_W'(LEV_N - 1)))
                    begin
                        tv_next         = 1'b1;
                        res_status_next = ST_DONE;
                        res_e_next      = '0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        lev_next = lev_reg + LEV_W'(1);
                        b_next   = '0;
                    end
                end
                else
                begin
                    sa_addr    = {lev_m1, b_reg};
                    sb_addr    = {lev_m1, b_reg + half};
                    state_next = S_SP_WR;
                end
            end

            S_SP_WR:
            begin
                s_we       = 1'b1;
                s_waddr    = {lev_reg, b_reg};
                s_wdata    = t_sel;
                b_next     = b_reg + BLK_W'(1);
                state_next = S_SP_RD;
            end

            S_Q_DIV:
                state_next = S_Q_PLAN;

            S_Q_PLAN:
            begin
                if (bi == bj)
                begin
                    k_next     = qi_reg;
                    state_next = S_SC_RD;
                end
                else
                begin
                    ea_addr    = {RG_SUF, qi_reg};
                    eb_addr    = {RG_PRE, qj_reg};
                    sa_addr    = {q_lev, bi_p1};
                    sb_addr    = {q_lev, bj - q_pow};
                    use_next   = (bi_p1 < bj);
                    state_next = S_Q_CMP1;
                end
            end

            S_Q_CMP1:
            begin
                run_next   = ea_q_reg;
                p_next     = eb_q_reg;
                tmp_next   = t_sel;
                state_next = S_Q_CMP2;
            end

            S_Q_CMP2:
            begin
                if (use_reg && less_e(tmp_reg, run_reg))
                    run_next = tmp_reg;
                state_next = S_Q_CMP3;
            end

            S_Q_CMP3:
            begin
                res_status_next = ST_ANSWER;
                res_e_next      = less_e(p_reg, run_reg) ? p_reg : run_reg;
                state_next      = S_EMIT;
            end

            // short range inside one block
            S_SC_RD:
            begin
                ea_addr    = {RG_VAL, k_reg};
                state_next = S_SC_CMP;
            end

            S_SC_CMP:
            begin
                run_next = run_scan;
                if (k_reg == qj_reg)
                begin
                    res_status_next = ST_ANSWER;
                    res_e_next      = run_scan;
                    state_next      = S_EMIT;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_SC_RD;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tv_reg        <= 1'b0;
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tv_reg        <= tv_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        blk_reg        <= blk_next;
        run_reg        <= run_next;
        tmp_reg        <= tmp_next;
        p_reg          <= p_next;
        fresh_reg      <= fresh_next;
        bc_reg         <= bc_next;
        lev_reg        <= lev_next;
        b_reg          <= b_next;
        qi_reg         <= qi_next;
        qj_reg         <= qj_next;
        use_reg        <= use_next;
        res_status_reg <= res_status_next;
        res_e_reg      <= res_e_next;
        out_status_reg <= out_status_next;
        out_e_reg      <= out_e_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign min_index = out_e_reg[E_W-1:VALUE_WIDTH];
    assign min_value = out_e_reg[VALUE_WIDTH-1:0];

`include "block_range_minimum_query_defines.svh"

    `BRMQ_ASSERT_SAME(a_done_has_tables,
        (state_reg == S_EMIT) && (res_status_reg == ST_DONE), tv_reg,
        "build done without valid tables")
    `BRMQ_ASSERT_SAME(a_answer_in_range,
        (state_reg == S_EMIT) && (res_status_reg == ST_ANSWER),
        (res_e_reg[E_W-1:VALUE_WIDTH] >= qi_reg) && (res_e_reg[E_W-1:VALUE_WIDTH] <= qj_reg),
        "answer index outside query range")
    `BRMQ_ASSERT_NEXT(a_busy_after_op,
        in_valid && !in_stall && ((opcode == OP_BUILD) || (opcode == OP_QUERY)), in_stall,
        "build or query did not hold the input")

endmodule

`default_nettype wire

// ===== bench/brmq_checker.sv =====
// Result checker for the block range-minimum-query unit: shadow state, prediction, compare.
`timescale 1ns / 100ps

module brmq_checker
    import brmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  op_t                opcode,
    input  logic [9:0]         left_index,
    input  logic [9:0]         right_index,
    input  logic signed [31:0] element_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  stat_t              status,
    input  logic [9:0]         min_index,
    input  logic signed [31:0] min_value,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        stat_t              st;
        logic [9:0]         idx;
        logic signed [31:0] val;
    } answer_t;

    logic signed [31:0] shadow_values [1024];
    int                 active_count;
    bit                 tables_ok;
    answer_t            answer_q[$];

    // Leftmost minimum over lo..hi of the shadow array.
    function automatic logic [9:0] leftmost_min(input int lo, input int hi);
        int best;
        best = lo;
        for (int k = lo + 1; k <= hi; k++)
            if (shadow_values[k] < shadow_values[best])
                best = k;
        return best[9:0];
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        fail_count++;
        $display("%0t mismatch: %s got %0h, want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        int      n;
        if (!rst_n)
        begin
            active_count = 1;
            tables_ok    = 0;
            fail_count   = 0;
            answer_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                n = cfg_wr_data;
                if (n == 0)
                    n = 1;
                if (n > 1024)
                    n = 1024;
                active_count = n;
                tables_ok    = 0;
            end
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_WRITE:
                    begin
                        shadow_values[left_index] = element_value;
                        tables_ok = 0;
                    end
                    OP_BUILD:
                    begin
                        tables_ok = 1;
                        answer_q.push_back('{ST_DONE, 10'd0, 32'sd0});
                    end
                    OP_QUERY:
                    begin
                        if (!tables_ok || left_index > right_index
                            || right_index >= active_count)
                            answer_q.push_back('{ST_ERROR, 10'd0, 32'sd0});
                        else
                        begin
                            a.st  = ST_ANSWER;
                            a.idx = leftmost_min(left_index, right_index);
                            a.val = shadow_values[a.idx];
                            answer_q.push_back(a);
                        end
                    end
                    default: ;  // unused code, no result
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                    report("unexpected word, status", status, 0);
                else
                begin
                    a = answer_q.pop_front();
                    if (status !== a.st)
                        report("status", status, a.st);
                    if (min_index !== a.idx)
                        report("min_index", min_index, a.idx);
                    if (min_value !== a.val)
                        report("min_value", min_value, a.val);
                end
            end
        end
        pending = answer_q.size();
    end

endmodule

// ===== bench/tb_block_range_minimum_query.sv =====
// Top-level testbench for the block range-minimum-query unit: stimulus and verdict.
`timescale 1ns / 100ps

module tb_block_range_minimum_query;
    import brmq_pkg::*;

    // Cycles with no handshake before the run is declared hung. The limit
    // covers a full-size build and the long output hold-off.
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_wr_en = 0;
    logic [10:0]        cfg_wr_data = '0;
    logic               in_valid = 0;
    logic               in_stall;
    op_t                opcode = OP_WRITE;
    logic [9:0]         left_index = '0;
    logic [9:0]         right_index = '0;
    logic signed [31:0] element_value = '0;
    logic               out_valid;
    logic               out_stall = 0;
    stat_t              status;
    logic [9:0]         min_index;
    logic signed [31:0] min_value;

    int fail_count;
    int pending;

    bit noise_on = 1;       // random idling on both sides
    bit hold_req = 0;       // ask the receiver for one long hold-off
    bit written [1024];     // entries stored so far; a build never reads past these
    int elem_count = 1;     // count as the unit applies it
    int n_writes, n_builds, n_queries, n_other;

    always #4 clk = ~clk;

    block_range_minimum_query dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .left_index(left_index), .right_index(right_index),
        .element_value(element_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .min_index(min_index), .min_value(min_value)
    );

    brmq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .left_index(left_index), .right_index(right_index),
        .element_value(element_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .min_index(min_index), .min_value(min_value),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: any handshake resets the count of quiet cycles.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("block_range_minimum_query test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // unit's output register fills and in_stall backs up onto the sender.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 0;
            end
            else if (noise_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
            out_stall <= (stall_left > 0);
        end
    end

    // Offer one word and hold it until taken. Entered and left at a falling edge.
    task automatic send_word(input op_t op, input int li, input int ri,
                             input logic [31:0] val);
        if (noise_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        opcode        <= op;
        left_index    <= li[9:0];
        right_index   <= ri[9:0];
        element_value <= val;
        in_valid      <= 1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        case (op)
            OP_WRITE: n_writes++;
            OP_BUILD: n_builds++;
            OP_QUERY: n_queries++;
            default:  n_other++;
        endcase
    endtask

    task automatic write_elem(input int addr, input logic [31:0] val);
        written[addr] = 1;
        send_word(OP_WRITE, addr, $urandom_range(0, 1023), val);
    endtask

    // Store every entry below the count that was never written, so a build
    // only reads defined values.
    task automatic fill_unwritten();
        for (int k = 0; k < elem_count; k++)
            if (!written[k])
                write_elem(k, $urandom);
    endtask

    // Count changes only with the unit idle: all answers back, then a pause
    // covering a trailing write that produces no result.
    task automatic set_count(input int raw);
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= raw[10:0];
        @(negedge clk);
        cfg_wr_en   <= 0;
        elem_count = (raw == 0) ? 1 : (raw > 1024) ? 1024 : raw;
    endtask

    task automatic random_query();
        int i, j, sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            // malformed: anything the fields allow
            i = $urandom_range(0, 1023);
            j = $urandom_range(0, 1023);
        end
        else if (sel < 40)
        begin
            // within one block
            i = $urandom_range(0, elem_count - 1);
            j = i + $urandom_range(0, 7 - i % 8);
            if (j >= elem_count)
                j = elem_count - 1;
        end
        else
        begin
            i = $urandom_range(0, elem_count - 1);
            j = $urandom_range(i, elem_count - 1);
        end
        send_word(OP_QUERY, i, j, $urandom);
    endtask

    // Mostly queries on built tables, with writes that invalidate them,
    // rebuilds, and the unused code mixed in.
    task automatic random_phase(input int items);
        int sel, addr;
        fill_unwritten();
        send_word(OP_BUILD, $urandom, $urandom, $urandom);
        for (int k = 0; k < items; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, elem_count - 1);
                // small values give ties often
                write_elem(addr, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
                if ($urandom_range(0, 9) < 7)
                    send_word(OP_BUILD, $urandom, $urandom, $urandom);
            end
            else if (sel < 11)
                send_word(OP_BUILD, $urandom, $urandom, $urandom);
            else if (sel < 13)
                send_word(op_t'(2'd3), $urandom, $urandom, $urandom);
            else
                random_query();
        end
    endtask

    initial
    begin
        int counts [10];
        counts = '{2, 0, 8, 9, 17, 64, 250, 1024, 2047, 1000};

        repeat (5) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: reset count of one, query before any build, unused code,
        // extreme values, ties, in-block and cross-block ranges, errors after a write and out of range.
        send_word(OP_QUERY, 0, 0, 0);
        send_word(op_t'(2'd3), 1023, 1023, 32'hFFFF_FFFF);
        write_elem(0, 32'h8000_0000);
        send_word(OP_BUILD, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 1, 1, 0);
        set_count(16);
        for (int k = 0; k < 16; k++)
            write_elem(k, (k == 3 || k == 12) ? 32'h8000_0000 :
                          (k % 2) ? 32'h7FFF_FFFF : 32'd5);
        send_word(OP_BUILD, 0, 0, 0);
        send_word(OP_QUERY, 0, 15, 0);
        send_word(OP_QUERY, 4, 11, 0);
        send_word(OP_QUERY, 5, 5, 0);
        send_word(OP_QUERY, 5, 2, 0);
        send_word(OP_QUERY, 0, 16, 0);
        write_elem(9, 32'h8000_0000);
        send_word(OP_QUERY, 4, 11, 0);
        send_word(OP_BUILD, 0, 0, 0);
        send_word(OP_QUERY, 1, 14, 0);

        // Random phases over a spread of counts; the long receiver hold-off
        // lands in one of them, and the last runs without idling.
        foreach (counts[p])
        begin
            set_count(counts[p]);
            if (p == 6)
                hold_req = 1;
            if (p == 9)
                noise_on = 0;
            random_phase(30);
        end

        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d writes, %0d builds, %0d queries, %0d unused-code words",
                 n_writes, n_builds, n_queries, n_other);
        $display("element counts from 1 to 1024, clamped writes of 0 and 2047 included");
        if (fail_count == 0)
            $display("block_range_minimum_query test passed");
        else
            $display("block_range_minimum_query test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/brmq_pkg.sv
hdl/brmq_blkdiv.sv
hdl/block_range_minimum_query.sv
bench/brmq_checker.sv
bench/tb_block_range_minimum_query.sv
